// ----- rtl/psrc_pkg.sv -----
package psrc_pkg;

    // fixed field widths
    localparam int COORD_W   = 16;
    localparam int STEP_W    = 16;
    localparam int FIELD_W   = 12;
    localparam int CFG_IDX_W = 1;

    // packed stream widths
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 32;

    // default fraction precision
    localparam int FRAC_BITS_DEF = 16;

    // register reset values
    localparam logic [FIELD_W-1:0] FIELD_WIDTH_RST  = 12'd800;
    localparam logic [FIELD_W-1:0] FIELD_HEIGHT_RST = 12'd600;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_HEIGHT = 1'b1;

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // sequencer states
    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_EVAL  = 11'b000_0000_0010,
        ST_DXS   = 11'b000_0000_0100,
        ST_DXW   = 11'b000_0000_1000,
        ST_DYS   = 11'b000_0001_0000,
        ST_DYW   = 11'b000_0010_0000,
        ST_SEL   = 11'b000_0100_0000,
        ST_MULX  = 11'b000_1000_0000,
        ST_MULY  = 11'b001_0000_0000,
        ST_ADDY  = 11'b010_0000_0000,
        ST_WRITE = 11'b100_0000_0000
    } psrc_state_t;

    // strobes from sequencer to datapath
    typedef struct packed {
        logic ready;
        logic eval;
        logic div_start;
        logic div_y;
        logic take_fx;
        logic take_fy;
        logic sel_f;
        logic mul_x;
        logic mul_y;
        logic add_y;
        logic write;
    } psrc_ctrl_t;

    // status from datapath to sequencer
    typedef struct packed {
        logic in_valid;
        logic is_load;
        logic ended;
        logic in_field;
        logic div_done;
        logic out_free;
    } psrc_status_t;

endpackage

// ----- rtl/psrc_div.sv -----
module psrc_div
    import psrc_pkg::*;
#(
    parameter int QW = FRAC_BITS_DEF,
    parameter int DW = COORD_W
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo,
    output logic          done
);

    localparam int CW = $clog2(QW + 1);

    logic [DW-1:0] rem_reg;
    logic [DW-1:0] rem_next;
    logic [DW-1:0] den_reg;
    logic [QW-1:0] quo_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          fits;

    // one restoring step: shift in a zero, subtract if it fits
    always_comb
    begin
        shifted  = {rem_reg, 1'b0};
        diff     = shifted - {1'b0, den_reg};
        fits     = (shifted >= {1'b0, den_reg});
        rem_next = fits ? diff[DW-1:0] : shifted[DW-1:0];
    end

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(QW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // partial remainder and quotient bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[QW-2:0], fits};
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

// ----- rtl/psrc_seq.sv -----
module psrc_seq
    import psrc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  psrc_status_t status,
    output psrc_ctrl_t   ctrl
);

    psrc_state_t state_reg;
    psrc_state_t state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (status.in_valid)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (status.is_load || status.ended || status.in_field)
                    state_next = ST_WRITE;
                else
                    state_next = ST_DXS;
            end
            ST_DXS:  state_next = ST_DXW;
            ST_DXW:
            begin
                if (status.div_done)
                    state_next = ST_DYS;
            end
            ST_DYS:  state_next = ST_DYW;
            ST_DYW:
            begin
                if (status.div_done)
                    state_next = ST_SEL;
            end
            ST_SEL:  state_next = ST_MULX;
            ST_MULX: state_next = ST_MULY;
            ST_MULY: state_next = ST_ADDY;
            ST_ADDY: state_next = ST_WRITE;
            ST_WRITE:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath strobes
    always_comb
    begin
        ctrl.ready     = (state_reg == ST_IDLE);
        ctrl.eval      = (state_reg == ST_EVAL);
        ctrl.div_start = (state_reg == ST_DXS) || (state_reg == ST_DYS);
        ctrl.div_y     = (state_reg == ST_DYS);
        ctrl.take_fx   = (state_reg == ST_DXW) && status.div_done;
        ctrl.take_fy   = (state_reg == ST_DYW) && status.div_done;
        ctrl.sel_f     = (state_reg == ST_SEL);
        ctrl.mul_x     = (state_reg == ST_MULX);
        ctrl.mul_y     = (state_reg == ST_MULY);
        ctrl.add_y     = (state_reg == ST_ADDY);
        ctrl.write     = (state_reg == ST_WRITE) && status.out_free;
    end

endmodule

// ----- rtl/point_step_rect_clip.sv -----
// sequence: a load, an ignored step or a step that stays inside goes from ST_EVAL to
//   ST_WRITE; a clipped step runs the bit-serial divider once per axis, then scales
//   both axes by the smaller fraction before ST_WRITE
// throughput: one word at a time; a new word is taken once the previous result is in the
//   output register, and ST_WRITE holds while that register is full and not taken
// reset: rst_n clears position and end flag, restores field size 800 x 600
module point_step_rect_clip
    import psrc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // pos_x[15:0], pos_y[31:16], load_end[32], step_x[48:33], step_y[64:49], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // cmd[0]
    input  logic [0:0]           s_tuser,
    // output stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // cur_x[15:0], cur_y[31:16]
    output logic [M_TDATA_W-1:0] m_tdata,
    // at_edge[0]
    output logic [0:0]           m_tuser,
    // configuration
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_data
);

    localparam int FW = FRAC_BITS + 1;
    localparam int PW = COORD_W + FW;
    localparam logic [FW-1:0] FRAC_ONE = FW'(1) << FRAC_BITS;

    psrc_ctrl_t   ctrl;
    psrc_status_t status;

    logic [FIELD_W-1:0] fw_reg;
    logic [FIELD_W-1:0] fh_reg;
    logic [COORD_W-1:0] w_px;
    logic [COORD_W-1:0] h_px;

    // architectural state
    logic [COORD_W-1:0] pos_x_reg;
    logic [COORD_W-1:0] pos_y_reg;
    logic               end_reg;

    // captured word
    logic               cmd_reg;
    logic [COORD_W-1:0] ld_x_reg;
    logic [COORD_W-1:0] ld_y_reg;
    logic               ld_end_reg;
    logic [STEP_W-1:0]  dx_reg;
    logic [STEP_W-1:0]  dy_reg;

    // working registers
    logic [COORD_W-1:0] px_reg;
    logic [COORD_W-1:0] py_reg;
    logic               lo_x_reg;
    logic               lo_y_reg;
    logic               vx_reg;
    logic               vy_reg;
    logic [FW-1:0]      fx_reg;
    logic [FW-1:0]      fy_reg;
    logic [FW-1:0]      f_reg;
    logic [PW-1:0]      prod_reg;
    logic [COORD_W-1:0] res_x_reg;
    logic [COORD_W-1:0] res_y_reg;
    logic               res_end_reg;

    // output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    logic               in_accept;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [17:0]        nx;
    logic [17:0]        ny;
    logic               lo_x;
    logic               hi_x;
    logic               lo_y;
    logic               hi_y;
    logic               in_field;
    logic [COORD_W-1:0] mag_x;
    logic [COORD_W-1:0] mag_y;
    logic [COORD_W-1:0] div_num;
    logic [COORD_W-1:0] div_den;
    logic [FRAC_BITS-1:0] div_quo;
    logic               div_done;
    logic [COORD_W-1:0] mul_a;
    logic [COORD_W-1:0] scaled;
    logic [COORD_W-1:0] add_p;
    logic               add_neg;
    logic [COORD_W-1:0] add_res;

    function automatic logic [COORD_W-1:0] clamp_to(input logic [COORD_W-1:0] v,
                                                    input logic [COORD_W-1:0] e);
        clamp_to = (v > e) ? e : v;
    endfunction

    function automatic logic [COORD_W-1:0] magnitude(input logic [STEP_W-1:0] d);
        magnitude = d[STEP_W-1] ? (~d + 1'b1) : d;
    endfunction

    // field edges in Q12.4
    assign w_px = {fw_reg, 4'b0000};
    assign h_px = {fh_reg, 4'b0000};

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= FIELD_WIDTH_RST;
            fh_reg <= FIELD_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FIELD_WIDTH:  fw_reg <= cfg_data;
                CFG_FIELD_HEIGHT: fh_reg <= cfg_data;
                default:          fw_reg <= fw_reg;
            endcase
        end
    end

    // inside test on the clamped held point
    always_comb
    begin
        cx       = clamp_to(pos_x_reg, w_px);
        cy       = clamp_to(pos_y_reg, h_px);
        nx       = {2'b00, cx} + {{2{dx_reg[STEP_W-1]}}, dx_reg};
        ny       = {2'b00, cy} + {{2{dy_reg[STEP_W-1]}}, dy_reg};
        lo_x     = nx[17];
        lo_y     = ny[17];
        hi_x     = !nx[17] && (nx[16:0] > {1'b0, w_px});
        hi_y     = !ny[17] && (ny[16:0] > {1'b0, h_px});
        in_field = !lo_x && !hi_x && !lo_y && !hi_y;
        mag_x    = magnitude(dx_reg);
        mag_y    = magnitude(dy_reg);
    end

    // divider operands: distance to the violated edge over the step size
    always_comb
    begin
        if (ctrl.div_y)
        begin
            div_num = lo_y_reg ? py_reg : (h_px - py_reg);
            div_den = mag_y;
        end
        else
        begin
            div_num = lo_x_reg ? px_reg : (w_px - px_reg);
            div_den = mag_x;
        end
    end

    psrc_div #(
        .QW (FRAC_BITS),
        .DW (COORD_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctrl.div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .done  (div_done)
    );

    // shared scaler: move one axis by the truncated scaled step
    always_comb
    begin
        scaled  = prod_reg[FRAC_BITS +: COORD_W];
        mul_a   = ctrl.mul_y ? mag_y : mag_x;
        add_p   = ctrl.add_y ? py_reg : px_reg;
        add_neg = ctrl.add_y ? dy_reg[STEP_W-1] : dx_reg[STEP_W-1];
        if (add_neg)
            add_res = (scaled > add_p) ? '0 : (add_p - scaled);
        else
            add_res = add_p + scaled;
        add_res = clamp_to(add_res, ctrl.add_y ? h_px : w_px);
    end

    assign in_accept = s_tvalid && s_tready;

    // capture of the incoming word
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg    <= s_tuser[0];
            ld_x_reg   <= s_tdata[15:0];
            ld_y_reg   <= s_tdata[31:16];
            ld_end_reg <= s_tdata[32];
            dx_reg     <= s_tdata[48:33];
            dy_reg     <= s_tdata[64:49];
        end
    end

    // working datapath
    always_ff @(posedge clk)
    begin
        if (ctrl.eval)
        begin
            px_reg   <= cx;
            py_reg   <= cy;
            lo_x_reg <= lo_x;
            lo_y_reg <= lo_y;
            vx_reg   <= lo_x || hi_x;
            vy_reg   <= lo_y || hi_y;
            if (cmd_reg == CMD_LOAD)
            begin
                res_x_reg   <= clamp_to(ld_x_reg, w_px);
                res_y_reg   <= clamp_to(ld_y_reg, h_px);
                res_end_reg <= ld_end_reg;
            end
            else if (end_reg)
            begin
                res_x_reg   <= pos_x_reg;
                res_y_reg   <= pos_y_reg;
                res_end_reg <= 1'b1;
            end
            else
            begin
                res_x_reg   <= nx[COORD_W-1:0];
                res_y_reg   <= ny[COORD_W-1:0];
                res_end_reg <= !in_field;
            end
        end
        if (ctrl.take_fx)
            fx_reg <= vx_reg ? {1'b0, div_quo} : FRAC_ONE;
        if (ctrl.take_fy)
            fy_reg <= vy_reg ? {1'b0, div_quo} : FRAC_ONE;
        if (ctrl.sel_f)
            f_reg <= (fx_reg <= fy_reg) ? fx_reg : fy_reg;
        if (ctrl.mul_x || ctrl.mul_y)
            prod_reg <= PW'(mul_a * f_reg);
        if (ctrl.mul_y)
            res_x_reg <= add_res;
        if (ctrl.add_y)
            res_y_reg <= add_res;
    end

    // position, end flag and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            end_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.write)
            begin
                pos_x_reg    <= res_x_reg;
                pos_y_reg    <= res_y_reg;
                end_reg      <= res_end_reg;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.write)
        begin
            m_tdata_reg <= {res_y_reg, res_x_reg};
            m_tuser_reg <= res_end_reg;
        end
    end

    // sequencer
    always_comb
    begin
        status.in_valid = s_tvalid;
        status.is_load  = (cmd_reg == CMD_LOAD);
        status.ended    = end_reg;
        status.in_field = in_field;
        status.div_done = div_done;
        status.out_free = !m_tvalid_reg || m_tready;
    end

    psrc_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    assign s_tready   = ctrl.ready;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

// ----- rtl/psrc_chk.sv -----
module psrc_chk
    import psrc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // one word at a time: busy right after a word is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a word is in progress");

    // a new result only appears after a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result shown without a word in progress");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result dropped or changed");

endmodule

bind point_step_rect_clip psrc_chk u_psrc_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
